// ===== rtl/core/shell_sort_keys_core_macros.svh =====
// ----------------------------------------------------------------------------
// Shell sort core assertion macros
// Concurrent assertion shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SHELL_SORT_KEYS_CORE_MACROS_SVH
`define SHELL_SORT_KEYS_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SSK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SSK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSK_ASSERT_IMP(lbl, ante, cons, msg)
`define SSK_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ssk_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell sort core package
// Sizes, queue word type and status structs shared by the sorter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ssk_pkg;

	localparam int MAX_KEYS    = 64;
	localparam int KEY_W       = 64;
	localparam int ADDR_W      = $clog2(MAX_KEYS);
	localparam int CNT_W       = $clog2(MAX_KEYS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one classified word between front and back
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             last;
		logic             drop;
	} q_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
	} fr_stat_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             loading;
	} bk_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssk_front.sv =====
// ----------------------------------------------------------------------------
// Shell sort front end
// Accepts input words, counts the open batch and marks words past capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ssk_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ssk_pkg::KEY_W-1:0]     in_key,
	input  wire logic                          in_last,
	output logic                               push_valid,
	input  wire logic                          push_ready,
	output ssk_pkg::q_item_t                   push_data,
	output ssk_pkg::fr_stat_t                  stat
);

	logic [ssk_pkg::CNT_W-1:0] cnt_q;
	logic                      full;

	assign full       = (cnt_q == ssk_pkg::CNT_W'(ssk_pkg::MAX_KEYS));
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// classify: a word beyond capacity is marked for drop
	always_comb begin
		push_data.key  = in_key;
		push_data.last = in_last;
		push_data.drop = full;
	end

	assign stat.cnt = cnt_q;

	// track fill of the open batch, restart on its closing word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_valid && push_ready) begin
			if (in_last) begin
				cnt_q <= '0;
			end else if (!full) begin
				cnt_q <= cnt_q + ssk_pkg::CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ssk_fifo.sv =====
// ----------------------------------------------------------------------------
// Shell sort queue
// Short word queue that decouples the front end from the sorting back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ssk_fifo (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire ssk_pkg::q_item_t in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output ssk_pkg::q_item_t out_data
);

	ssk_pkg::q_item_t             slot_q [ssk_pkg::QUEUE_DEPTH];
	logic [ssk_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ssk_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ssk_pkg::QCNT_W-1:0]   cnt_q;
	logic                         push;
	logic                         pop;

	assign in_ready  = (cnt_q != ssk_pkg::QCNT_W'(ssk_pkg::QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ssk_pkg::QPTR_W'(ssk_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + ssk_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ssk_pkg::QPTR_W'(ssk_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + ssk_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + ssk_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - ssk_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ssk_back.sv =====
// ----------------------------------------------------------------------------
// Shell sort back end
// Loads a batch into the key memory, runs the halving-gap Shell sort with a
// compare-swap sequencer, then streams the sorted keys out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ssk_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire ssk_pkg::q_item_t            in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ssk_pkg::KEY_W-1:0]        out_key,
	output logic                             out_last,
	output logic                             out_ovf,
	output ssk_pkg::bk_stat_t                stat
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_GAP,
		ST_ITER,
		ST_RD,
		ST_CMP,
		ST_SWAP,
		ST_EM_RD,
		ST_EM_LD
	} state_t;

	state_t                     state_q;
	logic [ssk_pkg::KEY_W-1:0]  key_store_q [ssk_pkg::MAX_KEYS];
	logic [ssk_pkg::KEY_W-1:0]  rd_a_q;
	logic [ssk_pkg::KEY_W-1:0]  rd_b_q;
	logic [ssk_pkg::CNT_W-1:0]  cnt_q;
	logic [ssk_pkg::CNT_W-1:0]  gap_q;
	logic [ssk_pkg::CNT_W-1:0]  i_q;
	logic [ssk_pkg::CNT_W-1:0]  j_q;
	logic [ssk_pkg::CNT_W-1:0]  k_q;
	logic                       dropped_q;
	logic                       out_valid_q;
	logic [ssk_pkg::KEY_W-1:0]  out_key_q;
	logic                       out_last_q;
	logic                       out_ovf_q;

	logic                       pop;
	logic [ssk_pkg::CNT_W-1:0]  next_cnt;
	logic [ssk_pkg::CNT_W-1:0]  jg;
	logic                       rd_en;
	logic [ssk_pkg::ADDR_W-1:0] rd_addr_a;
	logic [ssk_pkg::ADDR_W-1:0] rd_addr_b;
	logic                       wr_en;
	logic [ssk_pkg::ADDR_W-1:0] wr_addr;
	logic [ssk_pkg::KEY_W-1:0]  wr_data;
	logic                       out_free;
	logic                       em_last;

	assign in_ready  = (state_q == ST_LOAD);
	assign pop       = in_valid && in_ready;
	assign next_cnt  = cnt_q + ssk_pkg::CNT_W'(!in_data.drop);
	assign jg        = j_q + gap_q;
	assign out_free  = !out_valid_q || out_ready;
	assign em_last   = (k_q == cnt_q - ssk_pkg::CNT_W'(1));

	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;
	assign stat.cnt     = cnt_q;
	assign stat.loading = (state_q == ST_LOAD);

	// memory port selection
	always_comb begin
		rd_en     = 1'b0;
		rd_addr_a = j_q[ssk_pkg::ADDR_W-1:0];
		rd_addr_b = jg[ssk_pkg::ADDR_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = j_q[ssk_pkg::ADDR_W-1:0];
		wr_data   = rd_b_q;
		case (state_q)
			ST_LOAD: begin
				wr_en   = pop && !in_data.drop;
				wr_addr = cnt_q[ssk_pkg::ADDR_W-1:0];
				wr_data = in_data.key;
			end
			ST_RD: begin
				rd_en = 1'b1;
			end
			ST_CMP: begin
				wr_en = (rd_a_q > rd_b_q);
			end
			ST_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = jg[ssk_pkg::ADDR_W-1:0];
				wr_data = rd_a_q;
			end
			ST_EM_RD: begin
				rd_en     = 1'b1;
				rd_addr_a = k_q[ssk_pkg::ADDR_W-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// key memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_store_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= key_store_q[rd_addr_a];
			rd_b_q <= key_store_q[rd_addr_b];
		end
	end

	// sequencer: load, gapped insertion passes, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			gap_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_key_q   <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			// release the output word once taken; the emit state reloads it itself
			if (out_valid_q && out_ready && state_q != ST_EM_LD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						cnt_q     <= next_cnt;
						dropped_q <= dropped_q | in_data.drop;
						if (in_data.last) begin
							gap_q   <= next_cnt >> 1;
							state_q <= ST_GAP;
						end
					end
				end
				ST_GAP: begin
					if (gap_q == '0) begin
						k_q     <= '0;
						state_q <= ST_EM_RD;
					end else begin
						i_q     <= gap_q;
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					if (i_q >= cnt_q) begin
						gap_q   <= gap_q >> 1;
						state_q <= ST_GAP;
					end else begin
						j_q     <= i_q - gap_q;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rd_a_q > rd_b_q) begin
						state_q <= ST_SWAP;
					end else begin
						i_q     <= i_q + ssk_pkg::CNT_W'(1);
						state_q <= ST_ITER;
					end
				end
				ST_SWAP: begin
					// walk back by one gap while the pair was out of order
					if (j_q >= gap_q) begin
						j_q     <= j_q - gap_q;
						state_q <= ST_RD;
					end else begin
						i_q     <= i_q + ssk_pkg::CNT_W'(1);
						state_q <= ST_ITER;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_key_q   <= rd_a_q;
						out_last_q  <= em_last;
						out_ovf_q   <= dropped_q;
						if (em_last) begin
							cnt_q     <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							k_q     <= k_q + ssk_pkg::CNT_W'(1);
							state_q <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/shell_sort_keys_core.sv =====
// Batch key sorter. Keys (unsigned 64-bit) arrive one word per cycle on the
// slave stream while s_tready is high; s_tlast closes a batch of up to 64
// keys, and keys beyond 64 are dropped and flagged in m_tuser on every result
// of that batch. A two-word queue lets the next batch start arriving while
// the current one is sorted. The sort runs Shell's method with gaps n/2,
// n/4 and so on down to 1 on a key memory with one write port: each compare
// reads the pair, then compares with the first write, a swap adds the second
// write, each insertion step adds a pass through ST_ITER and each gap change
// one through ST_GAP, so a batch of n keys costs roughly n*log2(n) to n*n
// compares. The sorted keys then leave on the master stream in ascending
// order with m_tlast on the final one.
// ----------------------------------------------------------------------------
// Shell sort keys core
// Top level: front end, decoupling queue and sorting back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "shell_sort_keys_core_macros.svh"
module shell_sort_keys_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [ssk_pkg::KEY_W-1:0] s_tdata,   // [63:0] key
	input  wire logic                      s_tlast,   // last_in
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [ssk_pkg::KEY_W-1:0]      m_tdata,   // [63:0] sorted_key
	output logic                           m_tlast,   // last_out
	output logic                           m_tuser    // [0] overflow
);

	logic              push_valid;
	logic              push_ready;
	ssk_pkg::q_item_t  push_data;
	logic              q_valid;
	logic              q_ready;
	ssk_pkg::q_item_t  q_data;
	ssk_pkg::fr_stat_t fr_stat;
	ssk_pkg::bk_stat_t bk_stat;

	// accept and classify
	ssk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_key     (s_tdata),
		.in_last    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.stat       (fr_stat)
	);

	// decouple
	ssk_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	// store, sort, emit
	ssk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_data   (q_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_key   (m_tdata),
		.out_last  (m_tlast),
		.out_ovf   (m_tuser),
		.stat      (bk_stat)
	);

	// drop marks appear only once the front sees a full batch
	`SSK_ASSERT_IMP(a_drop_only_full, push_valid && push_data.drop,
		fr_stat.cnt == ssk_pkg::CNT_W'(ssk_pkg::MAX_KEYS), "drop mark below capacity")
	// back end never holds more keys than the memory
	`SSK_ASSERT_IMP(a_cnt_bound, 1'b1,
		bk_stat.cnt <= ssk_pkg::CNT_W'(ssk_pkg::MAX_KEYS), "stored count past capacity")
	// a closing word stops loading until the last sorted key is loaded for output
	`SSK_ASSERT_NXT(a_close_stops_load, q_valid && q_ready && q_data.last,
		!bk_stat.loading, "loading continued after closing word")
	// overflow flag holds steady across one batch of results
	`SSK_ASSERT_NXT(a_ovf_steady, m_tvalid && m_tready && !m_tlast,
		!m_tvalid || (m_tuser == $past(m_tuser)), "overflow changed within a batch")

endmodule
`default_nettype wire
